/* rtl/uer_pkg.sv */
package uer_pkg;

	// Register file
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int TRIG_LEN_W  = 8;
	localparam int GUARD_W     = 17;
	localparam int DIVISOR_W   = 16;
	localparam int DIST_W      = 16;

	localparam logic [TRIG_LEN_W-1:0] TRIG_LEN_RESET     = 8'd24;
	localparam logic [GUARD_W-1:0]    RISE_TIMEOUT_RESET = 17'd60000;
	localparam logic [GUARD_W-1:0]    FALL_TIMEOUT_RESET = 17'd120000;
	localparam logic [DIVISOR_W-1:0]  TICKS_PER_CM_RESET = 16'd116;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TRIGGER_LENGTH = 2'd0,
		REG_RISE_TIMEOUT   = 2'd1,
		REG_FALL_TIMEOUT   = 2'd2,
		REG_TICKS_PER_CM   = 2'd3
	} cfg_reg_t;

	// Measurement phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_RISE = 2'd2,
		PH_MEAS = 2'd3
	} phase_t;

	// Controller sequencing
	typedef enum logic [1:0] {
		CTL_RUN  = 2'd0,
		CTL_DIV  = 2'd1,
		CTL_DONE = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} item_t;

	typedef struct packed {
		logic              trigger;
		logic              busy_res;
		logic              done_res;
		logic              timed_out;
		logic [DIST_W-1:0] range_cm;
	} result_t;

	typedef struct packed {
		logic cfg_we;
		logic step;
		logic div_start;
		logic div_step;
		logic load_step;
		logic load_div;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_status_t;

endpackage

/* rtl/uer_ctrl.sv */
module uer_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  uer_pkg::dp_status_t status,
	output uer_pkg::dp_cmd_t    cmd
);

	uer_pkg::ctl_state_t state_q, state_d;
	logic                res_valid_q, res_valid_d;
	logic                out_free;

	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uer_pkg::CTL_RUN;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		cfg_ready  = 1'b0;
		// drop the beat once taken
		res_valid_d = res_valid_q && result_stall;
		case (state_q)
			uer_pkg::CTL_RUN: begin
				item_stall = !out_free;
				cfg_ready  = 1'b1;
				cmd.cfg_we = cfg_valid;
				if (item_valid && out_free) begin
					cmd.step = 1'b1;
					if (status.need_div) begin
						cmd.div_start = 1'b1;
						state_d       = uer_pkg::CTL_DIV;
					end else begin
						cmd.load_step = 1'b1;
						res_valid_d   = 1'b1;
					end
				end
			end
			uer_pkg::CTL_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = uer_pkg::CTL_DONE;
				end
			end
			uer_pkg::CTL_DONE: begin
				if (out_free) begin
					cmd.load_div = 1'b1;
					res_valid_d  = 1'b1;
					state_d      = uer_pkg::CTL_RUN;
				end
			end
			default: begin
				state_d = uer_pkg::CTL_RUN;
			end
		endcase
	end

endmodule

/* rtl/uer_datapath.sv */
module uer_datapath #(
	parameter int TICK_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  uer_pkg::item_t                      item,
	input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  uer_pkg::dp_cmd_t                    cmd,
	output uer_pkg::dp_status_t                 status,
	output uer_pkg::result_t                    result
);

	localparam int CNT_W = (TICK_WIDTH > 1) ? $clog2(TICK_WIDTH) : 1;
	localparam int QW    = (TICK_WIDTH > uer_pkg::DIST_W) ? TICK_WIDTH : uer_pkg::DIST_W;
	localparam int RW    = uer_pkg::DIVISOR_W;

	// Configuration registers
	logic [uer_pkg::TRIG_LEN_W-1:0] trig_len_q;
	logic [uer_pkg::GUARD_W-1:0]    rise_to_q;
	logic [uer_pkg::GUARD_W-1:0]    fall_to_q;
	logic [uer_pkg::DIVISOR_W-1:0]  tpc_q;

	// Measurement state
	uer_pkg::phase_t                phase_q, phase_d;
	logic [uer_pkg::TRIG_LEN_W-1:0] tc_q, tc_d;
	logic [uer_pkg::GUARD_W-1:0]    gc_q, gc_d, gc_inc;
	logic [TICK_WIDTH-1:0]          et_q, et_d;
	uer_pkg::result_t               step_res;

	// Divider
	logic [RW-1:0]         rem_q;
	logic [TICK_WIDTH-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [RW:0]           trial;
	logic                  ge;
	logic [QW-1:0]         quo_ext;
	logic [uer_pkg::DIST_W-1:0] dist_sat;
	uer_pkg::result_t      div_res;

	uer_pkg::result_t      result_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_len_q <= uer_pkg::TRIG_LEN_RESET;
			rise_to_q  <= uer_pkg::RISE_TIMEOUT_RESET;
			fall_to_q  <= uer_pkg::FALL_TIMEOUT_RESET;
			tpc_q      <= uer_pkg::TICKS_PER_CM_RESET;
		end else if (cmd.cfg_we) begin
			case (uer_pkg::cfg_reg_t'(cfg_index))
				uer_pkg::REG_TRIGGER_LENGTH: trig_len_q <= cfg_data[uer_pkg::TRIG_LEN_W-1:0];
				uer_pkg::REG_RISE_TIMEOUT:   rise_to_q  <= cfg_data[uer_pkg::GUARD_W-1:0];
				uer_pkg::REG_FALL_TIMEOUT:   fall_to_q  <= cfg_data[uer_pkg::GUARD_W-1:0];
				uer_pkg::REG_TICKS_PER_CM:   tpc_q      <= cfg_data[uer_pkg::DIVISOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign gc_inc = gc_q + 17'd1;

	// Advance the ranging sequence by one tick
	always_comb begin
		phase_d  = phase_q;
		tc_d     = tc_q;
		gc_d     = gc_q;
		et_d     = et_q;
		step_res = '0;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (item.start_req) begin
					phase_d          = uer_pkg::PH_TRIG;
					tc_d             = 8'd1;
					step_res.trigger = 1'b1;
				end
			end
			uer_pkg::PH_TRIG: begin
				if (tc_q >= trig_len_q) begin
					phase_d = uer_pkg::PH_RISE;
					gc_d    = '0;
				end else begin
					tc_d             = tc_q + 8'd1;
					step_res.trigger = 1'b1;
				end
			end
			uer_pkg::PH_RISE: begin
				if (item.echo) begin
					phase_d = uer_pkg::PH_MEAS;
					et_d    = TICK_WIDTH'(1);
					gc_d    = 17'd1;
					// a fall limit of one or less ends on the first high tick
					if (17'd1 >= fall_to_q) begin
						phase_d            = uer_pkg::PH_IDLE;
						step_res.done_res  = 1'b1;
						step_res.timed_out = 1'b1;
					end
				end else begin
					gc_d = gc_inc;
					if (gc_inc >= rise_to_q) begin
						phase_d            = uer_pkg::PH_IDLE;
						step_res.done_res  = 1'b1;
						step_res.timed_out = 1'b1;
					end
				end
			end
			uer_pkg::PH_MEAS: begin
				if (item.echo) begin
					gc_d = gc_inc;
					if (et_q != '1) begin
						et_d = et_q + TICK_WIDTH'(1);
					end
					if (gc_inc >= fall_to_q) begin
						phase_d            = uer_pkg::PH_IDLE;
						step_res.done_res  = 1'b1;
						step_res.timed_out = 1'b1;
					end
				end else begin
					phase_d           = uer_pkg::PH_IDLE;
					step_res.done_res = 1'b1;
				end
			end
			default: ;
		endcase
		step_res.busy_res = (phase_d != uer_pkg::PH_IDLE);
	end

	// Hold the measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			tc_q    <= '0;
			gc_q    <= '0;
			et_q    <= '0;
		end else if (cmd.step) begin
			phase_q <= phase_d;
			tc_q    <= tc_d;
			gc_q    <= gc_d;
			et_q    <= et_d;
		end
	end

	// Restoring divide, one quotient bit per cycle
	assign trial = {rem_q, quo_q[TICK_WIDTH-1]};
	assign ge    = (trial >= {1'b0, tpc_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CNT_W'(TICK_WIDTH - 1);
		end else if (cmd.div_step && (cnt_q != '0)) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= et_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? RW'(trial - {1'b0, tpc_q}) : trial[RW-1:0];
			quo_q <= {quo_q[TICK_WIDTH-2:0], ge};
		end
	end

	// Report the falling tick and the last divide step
	assign status = '{
		need_div: (phase_q == uer_pkg::PH_MEAS) && !item.echo,
		div_last: (cnt_q == '0)
	};

	// Saturate the quotient to the distance width
	assign quo_ext  = QW'(quo_q);
	assign dist_sat = (quo_ext > QW'(16'hFFFF)) ? 16'hFFFF : quo_ext[uer_pkg::DIST_W-1:0];

	// Build the finishing beat of a measured echo
	always_comb begin
		div_res          = '0;
		div_res.done_res = 1'b1;
		div_res.range_cm = dist_sat;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_step) begin
			result_q <= step_res;
		end else if (cmd.load_div) begin
			result_q <= div_res;
		end
	end

	assign result = result_q;

endmodule

/* rtl/ultrasonic_echo_ranger_top.sv */
// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   uer_pkg::item_t   (start_req, echo)
// result    out        result_valid/result_stall uer_pkg::result_t (trigger..range_cm)
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One result beat per item beat. An ordinary tick loads its beat directly; the tick on which
// echo falls first runs the bit-serial restoring divider, which turns echo ticks into
// centimetres (one quotient bit per cycle, then the load).
// Reset (arst_n low) restores the register defaults and returns the ranger to idle.
// A stalled result holds in the output register; a new item is taken in the same
// cycle the waiting result leaves. Configuration is taken only while no divide is pending.
module ultrasonic_echo_ranger_top #(
	parameter int TICK_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  uer_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output uer_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

	uer_pkg::dp_cmd_t    cmd;
	uer_pkg::dp_status_t status;

	uer_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.status       (status),
		.cmd          (cmd)
	);

	uer_datapath #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

/* rtl/uer_checker.sv */
module uer_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input uer_pkg::result_t                result
);

	// Hold a stalled result beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// Take no item while a result waits behind a stall
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("item accepted over a stalled result");

	// A timeout finishes the measurement with zero distance
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.timed_out |->
			result.done_res && !result.busy_res && (result.range_cm == '0))
		else $error("timeout beat malformed");

	// Drive the trigger only during a measurement
	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.trigger |-> result.busy_res && !result.done_res)
		else $error("trigger outside a measurement");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int TICK_W = 16;
	localparam int unsigned TICK_MAX = (1 << TICK_W) - 1;
	localparam int ITEM_TARGET = 830;
	localparam int LONG_ECHO = 120;

	// Short-hand results for rows that can be read off by eye
	localparam uer_pkg::result_t QUIET    = '0;
	localparam uer_pkg::result_t TRIG_HI  = '{1'b1, 1'b1, 1'b0, 1'b0, 16'd0};
	localparam uer_pkg::result_t TIMEOUT  = '{1'b0, 1'b0, 1'b1, 1'b1, 16'd0};
	localparam uer_pkg::result_t ZERO_DIV = '{1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF};

	typedef struct packed {
		logic                           wr;
		uer_pkg::cfg_reg_t              idx;
		logic [uer_pkg::CFG_DATA_W-1:0] data;
		logic                           start_req;
		logic                           echo;
		logic                           typed;
		uer_pkg::result_t               want;
	} script_row_t;

	// Directed script: register writes and ticks, typed results where obvious
	script_row_t script [27] = '{
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b1, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b0, 1'b1, QUIET},
		'{1'b1, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_RISE_TIMEOUT,   17'd0,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_FALL_TIMEOUT,   17'd2,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_TICKS_PER_CM,   17'd0,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b0, 1'b1, TRIG_HI},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b0, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b0, 1'b1, TIMEOUT},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b1, 1'b1, TRIG_HI},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b0, 1'b1, ZERO_DIV},
		'{1'b1, uer_pkg::REG_TICKS_PER_CM,   17'd1,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_FALL_TIMEOUT,   17'd0,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b1, 1'b1, TRIG_HI},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b1, 1'b1, TIMEOUT},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b0, 1'b1, QUIET},
		'{1'b1, uer_pkg::REG_FALL_TIMEOUT,   17'd131071, 1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_RISE_TIMEOUT,   17'd131071, 1'b0, 1'b0, 1'b0, QUIET},
		'{1'b1, uer_pkg::REG_TRIGGER_LENGTH, 17'd1,      1'b0, 1'b0, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b1, 1'b1, TRIG_HI},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b1, 1'b1, 1'b0, QUIET},
		'{1'b0, uer_pkg::REG_TRIGGER_LENGTH, 17'd0,      1'b0, 1'b0, 1'b0, QUIET}
	};

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            item_valid   = 1'b0;
	logic                            item_stall;
	uer_pkg::item_t                  item         = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	uer_pkg::result_t                result;
	logic                            cfg_valid    = 1'b0;
	logic                            cfg_ready;
	logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// Ranger state and register copy as the block should hold them
	uer_pkg::phase_t rg_phase;
	logic [7:0]      trig_cnt;
	logic [16:0]     guard_cnt;
	int unsigned     high_ticks;
	logic [7:0]      cfg_trig_len;
	logic [16:0]     cfg_rise_to;
	logic [16:0]     cfg_fall_to;
	logic [15:0]     cfg_div;

	uer_pkg::result_t pending_ranges [$];
	uer_pkg::result_t got_range;
	uer_pkg::result_t want_range;
	int              mismatches   = 0;
	int              n_items      = 0;
	int              stall_left   = 0;
	bit              src_jitter   = 1'b0;
	bit              sink_jitter  = 1'b0;

	ultrasonic_echo_ranger_top #(
		.TICK_WIDTH(TICK_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the ranger by one tick and return the beat it should emit
	function automatic uer_pkg::result_t advance_ranger(uer_pkg::item_t it);
		uer_pkg::result_t r;
		logic [31:0]      quot;
		r = '0;
		case (rg_phase)
			uer_pkg::PH_IDLE: begin
				if (it.start_req) begin
					rg_phase  = uer_pkg::PH_TRIG;
					trig_cnt  = 8'd1;
					r.trigger = 1'b1;
				end
			end
			uer_pkg::PH_TRIG: begin
				if (trig_cnt >= cfg_trig_len) begin
					rg_phase  = uer_pkg::PH_RISE;
					guard_cnt = '0;
				end else begin
					trig_cnt  = trig_cnt + 8'd1;
					r.trigger = 1'b1;
				end
			end
			uer_pkg::PH_RISE: begin
				if (it.echo) begin
					rg_phase   = uer_pkg::PH_MEAS;
					high_ticks = 1;
					guard_cnt  = 17'd1;
					if (guard_cnt >= cfg_fall_to) begin
						rg_phase    = uer_pkg::PH_IDLE;
						r.done_res  = 1'b1;
						r.timed_out = 1'b1;
					end
				end else begin
					guard_cnt = guard_cnt + 17'd1;
					if (guard_cnt >= cfg_rise_to) begin
						rg_phase    = uer_pkg::PH_IDLE;
						r.done_res  = 1'b1;
						r.timed_out = 1'b1;
					end
				end
			end
			default: begin
				if (it.echo) begin
					guard_cnt = guard_cnt + 17'd1;
					if (high_ticks < TICK_MAX)
						high_ticks++;
					if (guard_cnt >= cfg_fall_to) begin
						rg_phase    = uer_pkg::PH_IDLE;
						r.done_res  = 1'b1;
						r.timed_out = 1'b1;
					end
				end else begin
					rg_phase   = uer_pkg::PH_IDLE;
					r.done_res = 1'b1;
					if (cfg_div == '0) begin
						r.range_cm = 16'hFFFF;
					end else begin
						quot = high_ticks / cfg_div;
						r.range_cm = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
					end
				end
			end
		endcase
		r.busy_res = (rg_phase != uer_pkg::PH_IDLE);
		return r;
	endfunction

	task automatic flag_mismatch(string what, int unsigned want_v, int unsigned got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
	endtask

	// Send one tick beat, hold it until taken, then log its expected range beat
	task automatic send_tick(logic s, logic e, bit typed = 1'b0,
		uer_pkg::result_t want = '0);
		uer_pkg::item_t   it;
		uer_pkg::result_t predicted;
		if (src_jitter && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		it.start_req = s;
		it.echo      = e;
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		predicted = advance_ranger(it);
		pending_ranges.push_back(typed ? want : predicted);
		n_items++;
	endtask

	// Write one register once every outstanding beat has drained
	task automatic write_reg(uer_pkg::cfg_reg_t idx, logic [uer_pkg::CFG_DATA_W-1:0] value);
		item_valid <= 1'b0;
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (TICK_W + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			uer_pkg::REG_TRIGGER_LENGTH: cfg_trig_len = value[7:0];
			uer_pkg::REG_RISE_TIMEOUT:   cfg_rise_to  = value[16:0];
			uer_pkg::REG_FALL_TIMEOUT:   cfg_fall_to  = value[16:0];
			uer_pkg::REG_TICKS_PER_CM:   cfg_div      = value[15:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [7:0] tl, logic [16:0] rt, logic [16:0] ft, logic [15:0] dv);
		write_reg(uer_pkg::REG_TRIGGER_LENGTH, 17'(tl));
		write_reg(uer_pkg::REG_RISE_TIMEOUT, rt);
		write_reg(uer_pkg::REG_FALL_TIMEOUT, ft);
		write_reg(uer_pkg::REG_TICKS_PER_CM, 17'(dv));
	endtask

	// One ranging cycle: start, trigger, echo wait, echo pulse, fall
	task automatic run_ping(int max_low, int max_high);
		int n_low;
		int n_high;
		bit ragged;
		n_low  = $urandom_range(0, max_low);
		n_high = $urandom_range(1, max_high);
		ragged = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom));
		send_tick(1'b1, 1'($urandom));
		while (rg_phase == uer_pkg::PH_TRIG)
			send_tick(1'($urandom), 1'($urandom));
		while (rg_phase == uer_pkg::PH_RISE && n_low > 0) begin
			send_tick(1'($urandom), ragged ? 1'($urandom) : 1'b0);
			n_low--;
		end
		while (rg_phase != uer_pkg::PH_IDLE && n_high > 0) begin
			send_tick(1'($urandom), ragged ? 1'($urandom) : 1'b1);
			n_high--;
		end
		// Close out: raise echo if still waiting, then drop it
		while (rg_phase != uer_pkg::PH_IDLE)
			send_tick(1'($urandom), rg_phase == uer_pkg::PH_RISE);
	endtask

	// Stall the range beats in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (sink_jitter && $urandom_range(0, 9) == 0) begin
			stall_left   <= $urandom_range(0, 14);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Check each accepted range beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			got_range = result;
			if (pending_ranges.size() == 0) begin
				flag_mismatch("range beat with nothing pending, range_cm", 0,
					got_range.range_cm);
			end else begin
				want_range = pending_ranges.pop_front();
				if (got_range.trigger !== want_range.trigger)
					flag_mismatch("trigger", want_range.trigger, got_range.trigger);
				if (got_range.busy_res !== want_range.busy_res)
					flag_mismatch("busy_res", want_range.busy_res, got_range.busy_res);
				if (got_range.done_res !== want_range.done_res)
					flag_mismatch("done_res", want_range.done_res, got_range.done_res);
				if (got_range.timed_out !== want_range.timed_out)
					flag_mismatch("timed_out", want_range.timed_out, got_range.timed_out);
				if (got_range.range_cm !== want_range.range_cm)
					flag_mismatch("range_cm", want_range.range_cm,
						got_range.range_cm);
			end
		end
	end

	initial begin
		int          n_pings;
		logic [7:0]  tl;
		logic [16:0] rt;
		logic [16:0] ft;
		logic [15:0] dv;
		rg_phase     = uer_pkg::PH_IDLE;
		trig_cnt     = '0;
		guard_cnt    = '0;
		high_ticks   = 0;
		cfg_trig_len = uer_pkg::TRIG_LEN_RESET;
		cfg_rise_to  = uer_pkg::RISE_TIMEOUT_RESET;
		cfg_fall_to  = uer_pkg::FALL_TIMEOUT_RESET;
		cfg_div      = uer_pkg::TICKS_PER_CM_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed script
		foreach (script[i]) begin
			if (script[i].wr)
				write_reg(script[i].idx, script[i].data);
			else
				send_tick(script[i].start_req, script[i].echo, script[i].typed,
					script[i].want);
		end

		// Reset values, then the trigger and divisor extremes
		src_jitter  = 1'b1;
		sink_jitter = 1'b1;
		write_all(uer_pkg::TRIG_LEN_RESET, uer_pkg::RISE_TIMEOUT_RESET,
			uer_pkg::FALL_TIMEOUT_RESET, uer_pkg::TICKS_PER_CM_RESET);
		repeat (2) run_ping(8, 60);
		write_all(8'd255, 17'd1, 17'd1, 16'hFFFF);
		run_ping(3, 3);

		// Random register settings with mostly well-formed pings
		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: tl = 8'd0;
				1: tl = 8'($urandom_range(1, 4));
				2: tl = 8'($urandom_range(5, 12));
				default: tl = 8'd1;
			endcase
			case ($urandom_range(0, 2))
				0: rt = 17'd0;
				1: rt = 17'($urandom_range(1, 20));
				default: rt = 17'($urandom_range(0, 131071));
			endcase
			case ($urandom_range(0, 2))
				0: ft = 17'd0;
				1: ft = 17'($urandom_range(1, 40));
				default: ft = 17'($urandom_range(0, 131071));
			endcase
			case ($urandom_range(0, 3))
				0: dv = 16'd0;
				1: dv = 16'd1;
				2: dv = 16'($urandom_range(2, 16));
				default: dv = 16'($urandom_range(0, 65535));
			endcase
			write_all(tl, rt, ft, dv);
			src_jitter  = ($urandom_range(0, 3) != 0);
			sink_jitter = ($urandom_range(0, 3) != 0);
			n_pings = $urandom_range(6, 10);
			for (int p = 0; p < n_pings && n_items < ITEM_TARGET; p++)
				run_ping(25, 60);
		end

		// Last part runs at full rate: a long echo, then the largest divisor
		src_jitter  = 1'b0;
		sink_jitter = 1'b0;
		write_all(8'd1, 17'd131071, 17'd131071, 16'd1);
		send_tick(1'b1, 1'b0);
		while (rg_phase == uer_pkg::PH_TRIG)
			send_tick(1'b0, 1'b0);
		repeat (LONG_ECHO)
			send_tick(1'($urandom), 1'b1);
		send_tick(1'b0, 1'b0);
		write_reg(uer_pkg::REG_TICKS_PER_CM, 17'd65535);
		repeat (3) run_ping(10, 40);
		item_valid <= 1'b0;

		// Drain and let the block settle
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (TICK_W + 8) @(posedge clk);
		if (mismatches == 0)
			$display("** ultrasonic_echo_ranger_top: PASSED **");
		else
			$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

endmodule
